// File: hw/rtl/qssd_pkg.sv
// ----------------------------------------------------------------------------
// qssd_pkg
// Shared types, character constants and helpers for the query string
// splitter and decoder.
// ----------------------------------------------------------------------------
package qssd_pkg;

    // characters the splitter looks for
    localparam logic [7:0] C_PCT    = 8'h25;
    localparam logic [7:0] C_PLUS   = 8'h2B;
    localparam logic [7:0] C_EQ     = 8'h3D;
    localparam logic [7:0] C_AMP    = 8'h26;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_LOW_A  = 8'h61;
    localparam logic [7:0] C_LOW_F  = 8'h66;
    localparam logic [7:0] C_LOW_Z  = 8'h7A;
    localparam logic [7:0] C_UP_A   = 8'h41;
    localparam logic [7:0] C_UP_F   = 8'h46;
    localparam logic [7:0] C_DIG_0  = 8'h30;
    localparam logic [7:0] C_DIG_9  = 8'h39;
    localparam logic [7:0] C_NUL    = 8'h00;

    // result kind codes
    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // escape progress codes
    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_PCT   = 2'd1;
    localparam logic [1:0] ESC_DIGIT = 2'd2;

    // most results one input byte can cause
    localparam int MAX_RES = 3;

    typedef enum logic [1:0] {
        PH_SKIP  = 2'd0,
        PH_NAME  = 2'd1,
        PH_VALUE = 2'd2
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [1:0] esc;
        logic [7:0] held;
        logic       keep;
    } t_state;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
    } t_res;

    typedef struct packed {
        t_res [MAX_RES-1:0] res;
        logic [1:0]         count;
        logic               from_query;
    } t_bundle;

    typedef struct packed {
        logic       busy;
        logic [1:0] idx;
        logic [1:0] count;
    } t_ser_status;

    // hex digit value, anything else counts as zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= C_LOW_A && c <= C_LOW_F) begin
            v = c - C_LOW_A + 8'd10;
        end else if (c >= C_UP_A && c <= C_UP_F) begin
            v = c - C_UP_A + 8'd10;
        end else if (c >= C_DIG_0 && c <= C_DIG_9) begin
            v = c - C_DIG_0;
        end
        return v[3:0];
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == C_SPACE) || (c >= C_TAB && c <= C_CR);
    endfunction

endpackage

// File: hw/rtl/query_string_splitter_decoder_top.sv
// ----------------------------------------------------------------------------
// query_string_splitter_decoder_top
// Splits a query or cookie string into name=value pairs and decodes values.
// ----------------------------------------------------------------------------
// One string byte is taken per request on the slave stream and decoded in
// the same cycle into up to three results, which land in a result register
// and leave on the master stream one per cycle while it is ready. A byte
// that causes none or one result is followed by the next byte in the next
// cycle unless its result stalls; a byte with more results holds the input
// until the result register has handed out its last result. The separator
// register may be written only while no results are pending. No clearing pass after reset.
module query_string_splitter_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // string bytes
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // end_of_string
    // results
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [2:0] m_axis_tuser,   // [1:0] kind, [2] from_query
    output logic       m_axis_tlast,   // run_last
    // separator register
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic [7:0]            r_sep;
    qssd_pkg::t_state      r_state;
    qssd_pkg::t_state      n_state;
    qssd_pkg::t_bundle     bundle;
    qssd_pkg::t_res        res;
    qssd_pkg::t_ser_status ser_status;
    logic                  slot_free;
    logic                  in_acc;
    logic                  from_query;

    assign s_axis_tready = slot_free;
    assign in_acc        = s_axis_tvalid && slot_free;
    assign o_cfg_ready   = 1'b1;

    // separator register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= qssd_pkg::C_AMP;
        end else if (i_cfg_valid) begin
            r_sep <= i_cfg_data;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: qssd_pkg::PH_SKIP, esc: qssd_pkg::ESC_NONE,
                         held: 8'd0, keep: 1'b0};
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    qssd_decode u_decode (
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_sep    (r_sep),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_bundle (bundle)
    );

    qssd_serial u_serial (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (in_acc),
        .i_bundle     (bundle),
        .i_out_ready  (m_axis_tready),
        .o_slot_free  (slot_free),
        .o_valid      (m_axis_tvalid),
        .o_res        (res),
        .o_from_query (from_query),
        .o_last       (m_axis_tlast),
        .o_status     (ser_status)
    );

    assign m_axis_tdata = res.data;
    assign m_axis_tuser = {from_query, res.kind};

`ifndef SYNTHESIS
    // a pending result always points inside a non-empty bundle
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ser_status.busy |-> (ser_status.count != 2'd0 && ser_status.idx < ser_status.count))
        else $error("result index outside bundle");

    // no byte is taken while a stalled result would be overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("input accepted over stalled result");

    // a run continues after a non-final result is taken
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("result run broken");

    // an escape is only in progress inside a value
    a_esc_in_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.esc != qssd_pkg::ESC_NONE) |-> (r_state.phase == qssd_pkg::PH_VALUE))
        else $error("escape outside value");
`endif

endmodule

// File: hw/rtl/qssd_decode.sv
// ----------------------------------------------------------------------------
// qssd_decode
// Next-state and result logic for one input byte: splitting, name filter,
// plus and percent decoding, pair end flush.
// ----------------------------------------------------------------------------
module qssd_decode (
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic [7:0]       i_sep,
    input  qssd_pkg::t_state i_state,
    output qssd_pkg::t_state o_state,
    output qssd_pkg::t_bundle o_bundle
);

    qssd_pkg::t_state st;
    qssd_pkg::t_res [qssd_pkg::MAX_RES-1:0] res;
    logic [1:0] n;
    logic       do_end;
    logic [7:0] v;

    always_comb begin
        st     = i_state;
        res    = '0;
        n      = 2'd0;
        do_end = 1'b0;
        v      = {qssd_pkg::hex_value(i_state.held), qssd_pkg::hex_value(i_byte)};

        // main byte handling by phase
        case (i_state.phase)
            qssd_pkg::PH_NAME: begin
                if (i_byte == qssd_pkg::C_EQ) begin
                    st.esc   = qssd_pkg::ESC_NONE;
                    st.phase = qssd_pkg::PH_VALUE;
                end else if (i_byte == i_sep) begin
                    do_end = 1'b1;
                end else if (i_state.keep) begin
                    res[n] = '{data: i_byte, kind: qssd_pkg::KIND_NAME};
                    n      = n + 2'd1;
                end
            end
            qssd_pkg::PH_VALUE: begin
                if (i_byte == i_sep) begin
                    do_end = 1'b1;
                end else if (i_state.esc == qssd_pkg::ESC_PCT) begin
                    st.held = i_byte;
                    st.esc  = qssd_pkg::ESC_DIGIT;
                end else if (i_state.esc == qssd_pkg::ESC_DIGIT) begin
                    st.esc  = qssd_pkg::ESC_NONE;
                    st.held = 8'd0;
                    if (i_state.keep) begin
                        res[n] = '{data: v, kind: qssd_pkg::KIND_VALUE};
                        n      = n + 2'd1;
                    end
                end else if (i_byte == qssd_pkg::C_PCT) begin
                    st.esc = qssd_pkg::ESC_PCT;
                end else if (i_state.keep) begin
                    res[n] = '{data: (i_byte == qssd_pkg::C_PLUS) ? qssd_pkg::C_SPACE
                                                                   : i_byte,
                               kind: qssd_pkg::KIND_VALUE};
                    n      = n + 2'd1;
                end
            end
            default: begin
                // skipping leading space; unused code behaves the same
                st.phase = qssd_pkg::PH_SKIP;
                if (!qssd_pkg::is_space(i_byte)) begin
                    if (i_byte == qssd_pkg::C_EQ) begin
                        st.keep  = 1'b0;
                        st.esc   = qssd_pkg::ESC_NONE;
                        st.phase = qssd_pkg::PH_VALUE;
                    end else if (i_byte == i_sep) begin
                        st.keep = 1'b0;
                    end else begin
                        st.keep  = (i_byte >= qssd_pkg::C_LOW_A) &&
                                   (i_byte <= qssd_pkg::C_LOW_Z);
                        st.phase = qssd_pkg::PH_NAME;
                        if (st.keep) begin
                            res[n] = '{data: i_byte, kind: qssd_pkg::KIND_NAME};
                            n      = n + 2'd1;
                        end
                    end
                end
            end
        endcase

        // pair end: separator or end of string, flush a cut-short escape
        if (do_end || i_last) begin
            if (st.keep && st.phase != qssd_pkg::PH_SKIP) begin
                if (st.phase == qssd_pkg::PH_VALUE && st.esc != qssd_pkg::ESC_NONE) begin
                    res[n] = '{data: qssd_pkg::C_PCT, kind: qssd_pkg::KIND_VALUE};
                    n      = n + 2'd1;
                    if (st.esc == qssd_pkg::ESC_DIGIT) begin
                        res[n] = '{data: st.held, kind: qssd_pkg::KIND_VALUE};
                        n      = n + 2'd1;
                    end
                end
                res[n] = '{data: qssd_pkg::C_NUL, kind: qssd_pkg::KIND_END};
                n      = n + 2'd1;
            end
            st = '{phase: qssd_pkg::PH_SKIP, esc: qssd_pkg::ESC_NONE,
                   held: 8'd0, keep: 1'b0};
        end
    end

    assign o_state             = st;
    assign o_bundle.res        = res;
    assign o_bundle.count      = n;
    assign o_bundle.from_query = (i_sep == qssd_pkg::C_AMP);

endmodule

// File: hw/rtl/qssd_serial.sv
// ----------------------------------------------------------------------------
// qssd_serial
// Result register holding the results of one byte, handed out one per
// cycle while the output is ready, with the last one flagged.
// ----------------------------------------------------------------------------
module qssd_serial (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  qssd_pkg::t_bundle     i_bundle,
    input  logic                  i_out_ready,
    output logic                  o_slot_free,
    output logic                  o_valid,
    output qssd_pkg::t_res        o_res,
    output logic                  o_from_query,
    output logic                  o_last,
    output qssd_pkg::t_ser_status o_status
);

    qssd_pkg::t_bundle r_bundle;
    logic              r_busy;
    logic [1:0]        r_idx;
    logic              last_one;

    // free when empty or the final result leaves this cycle
    assign last_one    = (r_idx == (r_bundle.count - 2'd1));
    assign o_slot_free = !r_busy || (i_out_ready && last_one);

    // control: occupancy and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (i_load) begin
            r_busy <= (i_bundle.count != 2'd0);
            r_idx  <= 2'd0;
        end else if (r_busy && i_out_ready) begin
            if (last_one) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

    assign o_valid      = r_busy;
    assign o_res        = r_bundle.res[r_idx];
    assign o_from_query = r_bundle.from_query;
    assign o_last       = last_one;
    assign o_status     = '{busy: r_busy, idx: r_idx, count: r_bundle.count};

endmodule
